@@ rtl/core/lgeu_pkg.sv @@
`default_nettype none

package lgeu_pkg;

   // grid limits
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_AW   = $clog2(MAX_ROWS);
   localparam int COL_AW   = $clog2(MAX_COLS);

   // field and register widths
   localparam int CMD_W      = 2;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int SIZE_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // sweep counter holds up to rows + 3
   localparam int CNT_W = $clog2(MAX_ROWS + 4);

   // commands
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FILL  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP = 2'd2;

   // B3/S23
   localparam logic [3:0] NEIS_BIRTH = 4'd3;
   localparam logic [3:0] NEIS_KEEP  = 4'd2;

   // one column of the three-row window
   typedef struct packed {
      logic up;
      logic mid;
      logic down;
   } lgeu_tap_type;

   typedef struct packed {
      logic              shift;
      logic              wrap;
      logic              row_edge;
      logic [COL_AW:0]   cols;
   } lgeu_ctl_type;

   function automatic logic [ROW_AW:0] clamp_rows(input logic [SIZE_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) begin
         return (ROW_AW+1)'(1);
      end else if (w > 32'(MAX_ROWS)) begin
         return (ROW_AW+1)'(MAX_ROWS);
      end
      return (ROW_AW+1)'(w);
   endfunction

   function automatic logic [COL_AW:0] clamp_cols(input logic [SIZE_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) begin
         return (COL_AW+1)'(1);
      end else if (w > 32'(MAX_COLS)) begin
         return (COL_AW+1)'(MAX_COLS);
      end
      return (COL_AW+1)'(w);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/lgeu_ram.sv @@
`default_nettype none

module lgeu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/lgeu_cell.sv @@
`default_nettype none

module lgeu_cell (
   input  wire logic                  clock,
   input  wire lgeu_pkg::lgeu_ctl_type ctl,
   input  wire logic                  load_bit,
   input  wire logic                  active,
   input  wire logic                  col_edge,
   input  wire lgeu_pkg::lgeu_tap_type left_tap,
   input  wire lgeu_pkg::lgeu_tap_type right_tap,
   output lgeu_pkg::lgeu_tap_type     own_tap,
   output logic                       next_bit
);
   import lgeu_pkg::*;

   logic       up_ff, mid_ff, down_ff;
   logic [3:0] neis;
   logic       kill;
   logic       rule_bit;

   // window moves down one row per shift
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         up_ff   <= mid_ff;
         mid_ff  <= down_ff;
         down_ff <= load_bit;
      end
   end

   assign own_tap = '{up: up_ff, mid: mid_ff, down: down_ff};

   assign neis = 4'(left_tap.up) + 4'(up_ff) + 4'(right_tap.up)
               + 4'(left_tap.mid) + 4'(right_tap.mid)
               + 4'(left_tap.down) + 4'(down_ff) + 4'(right_tap.down);

   assign kill     = !ctl.wrap && (ctl.row_edge || col_edge);
   assign rule_bit = (neis == NEIS_BIRTH) || ((neis == NEIS_KEEP) && mid_ff);

   // columns outside the area in use keep their old value
   assign next_bit = !active ? mid_ff : (kill ? 1'b0 : rule_bit);

endmodule

`default_nettype wire

@@ rtl/core/lgeu_row.sv @@
`default_nettype none

module lgeu_row (
   input  wire logic                            clock,
   input  wire lgeu_pkg::lgeu_ctl_type          ctl,
   input  wire logic [lgeu_pkg::MAX_COLS-1:0]   load_row,
   output logic      [lgeu_pkg::MAX_COLS-1:0]   next_row
);
   import lgeu_pkg::*;

   lgeu_tap_type      taps [MAX_COLS];
   lgeu_tap_type      wrap_tap;
   logic [COL_AW-1:0] last_col;

   assign last_col = COL_AW'(ctl.cols - 1'b1);
   assign wrap_tap = taps[last_col];

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
      lgeu_tap_type left_tap;
      lgeu_tap_type right_tap;
      logic         is_last;

      assign is_last = (last_col == COL_AW'(j));

      if (j == 0) begin : g_first
         assign left_tap = wrap_tap;
      end else begin : g_inner_l
         assign left_tap = taps[j-1];
      end

      if (j == MAX_COLS - 1) begin : g_end
         assign right_tap = taps[0];
      end else begin : g_inner_r
         assign right_tap = is_last ? taps[0] : taps[j+1];
      end

      lgeu_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_bit  (load_row[j]),
         .active    ((COL_AW+1)'(j) < ctl.cols),
         .col_edge  ((j == 0) || is_last),
         .left_tap  (left_tap),
         .right_tap (right_tap),
         .own_tap   (taps[j]),
         .next_bit  (next_row[j])
      );
   end

endmodule

`default_nettype wire

@@ rtl/core/life_generation_engine_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake             Payload
// req       in   req_valid/req_stall   command, row, col, value
// rsp       out  rsp_valid/rsp_stall   cell_value, bad_address
// csr       in   csr_write             csr_index, csr_data
//
// One command at a time. Write and read first read the addressed row, then write it back
// or return the bit (a bad address skips the read); fill merges each row in; the step streams
// the rows through a 64-cell window row, one grid memory read and write a cycle.
// Synchronous reset; the grid reads dead until a row is first written.
// The result sits in an output register, so a stalled rsp does not block the next accept.
module life_generation_engine_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [lgeu_pkg::CMD_W-1:0]        req_command,
   input  wire logic [lgeu_pkg::ROW_W-1:0]        req_row,
   input  wire logic [lgeu_pkg::COL_W-1:0]        req_col,
   input  wire logic                              req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_cell_value,
   output logic                                   rsp_bad_address,
   input  wire logic                              csr_write,
   input  wire logic [lgeu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lgeu_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lgeu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [SIZE_W-1:0]   rows_cfg_ff, cols_cfg_ff;
   logic                wrap_cfg_ff;
   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                value_ff;
   logic [MAX_ROWS-1:0] row_valid_ff;
   logic                rdv_ff;
   logic [MAX_COLS-1:0] first_ff;
   logic                res_cell_ff, res_cell_in;
   logic                res_bad_ff, res_bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_cell_ff, rsp_bad_ff;

   logic [ROW_AW:0]     rs;
   logic [COL_AW:0]     cs;
   logic [31:0]         cnt_w, rs_w;
   logic                addr_ok;
   logic                accept, out_free, last;
   logic [COL_AW-1:0]   col_idx;
   logic [MAX_COLS-1:0] col_mask;

   logic                rd_en, wr_en;
   logic [ROW_AW-1:0]   rd_addr, wr_addr;
   logic [MAX_COLS-1:0] wr_data, rd_data, rd_row;
   logic [MAX_COLS-1:0] load_row, next_row;
   logic                capture_first;
   lgeu_ctl_type        ctl;

   assign rs      = clamp_rows(rows_cfg_ff);
   assign cs      = clamp_cols(cols_cfg_ff);
   assign cnt_w   = 32'(cnt_ff);
   assign rs_w    = 32'(rs);
   assign addr_ok = (32'(row_ff) < rs_w) && (32'(col_ff) < 32'(cs));
   assign col_idx = COL_AW'(col_ff);
   assign rd_row  = rdv_ff ? rd_data : '0;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = (32'(j) < 32'(cs));
      end
   end

   // per-command sequencing over the sweep counter
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_row;
      load_row      = rd_row;
      capture_first = 1'b0;
      last          = 1'b0;
      res_cell_in   = 1'b0;
      res_bad_in    = 1'b0;
      ctl.shift     = 1'b0;
      ctl.wrap      = wrap_cfg_ff;
      ctl.row_edge  = 1'b0;
      ctl.cols      = cs;
      if (state_ff == ST_RUN) begin
         case (cmd_ff)
            CMD_WRITE: begin
               if (!addr_ok) begin
                  last       = 1'b1;
                  res_bad_in = 1'b1;
               end else if (cnt_w == 32'd0) begin
                  rd_en   = 1'b1;
                  rd_addr = ROW_AW'(row_ff);
               end else begin
                  wr_en            = 1'b1;
                  wr_addr          = ROW_AW'(row_ff);
                  wr_data[col_idx] = value_ff;
                  last             = 1'b1;
               end
            end
            CMD_READ: begin
               if (!addr_ok) begin
                  last       = 1'b1;
                  res_bad_in = 1'b1;
               end else if (cnt_w == 32'd0) begin
                  rd_en   = 1'b1;
                  rd_addr = ROW_AW'(row_ff);
               end else begin
                  res_cell_in = rd_row[col_idx];
                  last        = 1'b1;
               end
            end
            CMD_FILL: begin
               // read row r, merge and write it back in the following cycle
               if (cnt_w < rs_w) begin
                  rd_en   = 1'b1;
                  rd_addr = ROW_AW'(cnt_ff);
               end
               if (cnt_w >= 32'd1) begin
                  wr_en   = 1'b1;
                  wr_addr = ROW_AW'(cnt_ff - 1'b1);
                  wr_data = (rd_row & ~col_mask) | (value_ff ? col_mask : '0);
               end
               if (cnt_w == rs_w) begin
                  last = 1'b1;
               end
            end
            default: begin
               // stream: last row, rows 0..rows-1, then the held copy of row 0
               if (cnt_w <= rs_w) begin
                  rd_en   = 1'b1;
                  rd_addr = (cnt_w == 32'd0) ? ROW_AW'(rs - 1'b1) : ROW_AW'(cnt_ff - 1'b1);
               end
               if ((cnt_w >= 32'd1) && (cnt_w <= rs_w + 32'd2)) begin
                  ctl.shift = 1'b1;
                  if (cnt_w == rs_w + 32'd2) begin
                     load_row = first_ff;
                  end
               end
               capture_first = (cnt_w == 32'd2);
               if (cnt_w >= 32'd4) begin
                  wr_en        = 1'b1;
                  wr_addr      = ROW_AW'(cnt_ff - 3'd4);
                  wr_data      = next_row;
                  ctl.row_edge = (cnt_w == 32'd4) || (cnt_w == rs_w + 32'd3);
               end
               if (cnt_w == rs_w + 32'd3) begin
                  last = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (last) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= SIZE_W'(MAX_ROWS);
         cols_cfg_ff  <= SIZE_W'(MAX_COLS);
         wrap_cfg_ff  <= 1'b1;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         row_valid_ff <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= row_valid_ff[rd_addr];
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_ROWS: rows_cfg_ff <= csr_data;
               CSR_COLS: cols_cfg_ff <= csr_data;
               CSR_WRAP: wrap_cfg_ff <= csr_data[0];
               default:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         row_ff   <= req_row;
         col_ff   <= req_col;
         value_ff <= req_value;
      end
      if (capture_first) begin
         first_ff <= rd_row;
      end
      if ((state_ff == ST_RUN) && last) begin
         res_cell_ff <= res_cell_in;
         res_bad_ff  <= res_bad_in;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_cell_ff <= res_cell_ff;
         rsp_bad_ff  <= res_bad_ff;
      end
   end

   lgeu_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgeu_row u_row (
      .clock    (clock),
      .ctl      (ctl),
      .load_row (load_row),
      .next_row (next_row)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = rsp_cell_ff;
   assign rsp_bad_address = rsp_bad_ff;

endmodule

`default_nettype wire
